>>> hw/rtl/edf_pkg.sv
package edf_pkg;

    localparam int TICK_W        = 32;
    localparam int STATUS_W      = 2;
    localparam int TIDX_W        = 3;
    localparam int MASK_W        = 8;
    localparam int MAX_TASKS_DEF = 8;

    localparam logic [STATUS_W-1:0] ST_SELECTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IDLE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ADDED    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    localparam logic OP_ADD      = 1'b0;
    localparam logic OP_SCHEDULE = 1'b1;

    typedef struct packed {
        logic [TICK_W-1:0] dl;
        logic [TICK_W-1:0] wc;
        logic [TICK_W-1:0] per;
        logic [TICK_W-1:0] ls;
        logic [TICK_W-1:0] cc;
    } t_task;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD1,
        S_ADD2,
        S_RD,
        S_HOR,
        S_TEST,
        S_RST,
        S_WIN1,
        S_WIN2
    } t_state;

endpackage

>>> hw/rtl/edf_ram.sv
module edf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

>>> hw/rtl/edf_latest_start_scheduler.sv
// Latest-start scheduler over a table of periodic tasks.
// Command port: drive the item fields and raise start; the item is taken at a
// clock edge where start is high and busy is low. busy stays high while the
// item is worked on. The result (status, task_index, missed_mask) is on the
// o_ ports for exactly one cycle with o_done high and must be taken then.
// busy is already low in that cycle, so the next start may be taken at the
// same edge that takes the result.
// An add sums tick and deadline, subtracts the wcet and writes the entry;
// an add to a full table is answered from idle. A schedule reads each
// task in the table, restarts any whose latest start was missed, and
// updates the selected task, if any. Each task costs one registered table
// read and one or two passes through the single shared 32-bit adder,
// which also computes every latest start and call count update.
// Reset (synchronous, active low) empties the table and idles the block;
// table entries hold no reset value and are written by adds before use.
// The receiver cannot stall: each result beat is shown for one cycle only.
module edf_latest_start_scheduler #(
    parameter int MAX_TASKS = edf_pkg::MAX_TASKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_operation,
    input  logic [edf_pkg::TICK_W-1:0]    i_current_tick,
    input  logic [edf_pkg::TICK_W-1:0]    i_relative_deadline,
    input  logic [edf_pkg::TICK_W-1:0]    i_worst_case_time,
    input  logic [edf_pkg::TICK_W-1:0]    i_task_period,
    output logic                          o_done,
    output logic [edf_pkg::STATUS_W-1:0]  o_status,
    output logic [edf_pkg::TIDX_W-1:0]    o_task_index,
    output logic [edf_pkg::MASK_W-1:0]    o_missed_mask
);
    import edf_pkg::*;

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_i, n_i;
    logic r_have, n_have;
    logic [IW-1:0] r_best_idx, n_best_idx;
    t_task r_best, n_best;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [TICK_W-1:0] r_dl, n_dl;
    logic [TICK_W-1:0] r_wc, n_wc;
    logic [TICK_W-1:0] r_per, n_per;
    logic [TICK_W-1:0] r_acc, n_acc;
    logic [MASK_W-1:0] r_missed, n_missed;
    logic r_done, n_done;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [TIDX_W-1:0] r_tidx, n_tidx;

    logic ram_we, ram_re;
    logic [IW-1:0] ram_waddr, ram_raddr;
    t_task ram_d, ram_q;

    logic [TICK_W-1:0] alu_a, alu_b, alu_y;
    logic alu_sub;
    logic better;

    edf_ram #(
        .WIDTH ($bits(t_task)),
        .DEPTH (MAX_TASKS),
        .AW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_d),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // shared adder: operand selection by step
    always_comb begin
        alu_a   = r_tick;
        alu_b   = r_dl;
        alu_sub = 1'b0;
        case (r_state)
            S_ADD2: begin
                alu_a   = r_acc;
                alu_b   = r_wc;
                alu_sub = 1'b1;
            end
            S_HOR: begin
                alu_a = r_tick;
                alu_b = ram_q.dl;
            end
            S_RST: begin
                alu_a   = r_acc;
                alu_b   = ram_q.wc;
                alu_sub = 1'b1;
            end
            S_WIN1: begin
                alu_a = r_best.ls;
                alu_b = r_best.per;
            end
            S_WIN2: begin
                alu_a = r_best.cc;
                alu_b = TICK_W'(1);
            end
            default: begin
                alu_a = r_tick;
                alu_b = r_dl;
            end
        endcase
    end

    assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    // earlier latest start wins, then lower call count, then lower index
    assign better = !r_have || (ram_q.ls < r_best.ls) ||
                    ((ram_q.ls == r_best.ls) && (ram_q.cc < r_best.cc));

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_i        = r_i;
        n_have     = r_have;
        n_best_idx = r_best_idx;
        n_best     = r_best;
        n_tick     = r_tick;
        n_dl       = r_dl;
        n_wc       = r_wc;
        n_per      = r_per;
        n_acc      = r_acc;
        n_missed   = r_missed;
        n_done     = 1'b0;
        n_status   = r_status;
        n_tidx     = r_tidx;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = r_count[IW-1:0];
        ram_raddr  = r_i[IW-1:0];
        ram_d      = ram_q;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_tick = i_current_tick;
                    n_dl   = i_relative_deadline;
                    n_wc   = i_worst_case_time;
                    n_per  = i_task_period;
                    if (i_operation == OP_ADD) begin
                        if (r_count == CW'(MAX_TASKS)) begin
                            n_done   = 1'b1;
                            n_status = ST_FULL;
                            n_tidx   = '0;
                            n_missed = '0;
                        end else begin
                            n_state = S_ADD1;
                        end
                    end else begin
                        n_i      = '0;
                        n_have   = 1'b0;
                        n_missed = '0;
                        n_state  = S_RD;
                    end
                end
            end
            S_ADD1: begin
                n_acc   = alu_y;
                n_state = S_ADD2;
            end
            S_ADD2: begin
                ram_we    = 1'b1;
                ram_waddr = r_count[IW-1:0];
                ram_d     = '{dl: r_dl, wc: r_wc, per: r_per, ls: alu_y, cc: '0};
                n_count   = r_count + 1'b1;
                n_done    = 1'b1;
                n_status  = ST_ADDED;
                n_tidx    = TIDX_W'(r_count);
                n_missed  = '0;
                n_state   = S_IDLE;
            end
            S_RD: begin
                if (r_i == r_count) begin
                    if (r_have) begin
                        n_state = S_WIN1;
                    end else begin
                        n_done   = 1'b1;
                        n_status = ST_IDLE;
                        n_tidx   = '0;
                        n_state  = S_IDLE;
                    end
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_HOR;
                end
            end
            S_HOR: begin
                // horizon = tick + deadline
                n_acc   = alu_y;
                n_state = S_TEST;
            end
            S_TEST: begin
                if (ram_q.ls > r_acc) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_RD;
                end else if (ram_q.ls < r_tick) begin
                    n_state = S_RST;
                end else begin
                    if (better) begin
                        n_have     = 1'b1;
                        n_best     = ram_q;
                        n_best_idx = r_i[IW-1:0];
                    end
                    n_i     = r_i + 1'b1;
                    n_state = S_RD;
                end
            end
            S_RST: begin
                ram_we    = 1'b1;
                ram_waddr = r_i[IW-1:0];
                ram_d     = ram_q;
                ram_d.ls  = alu_y;
                if (32'(r_i) < 32'(MASK_W)) begin
                    n_missed = r_missed | (MASK_W'(1) << r_i);
                end
                n_i     = r_i + 1'b1;
                n_state = S_RD;
            end
            S_WIN1: begin
                n_acc   = alu_y;
                n_state = S_WIN2;
            end
            S_WIN2: begin
                ram_we    = 1'b1;
                ram_waddr = r_best_idx;
                ram_d     = r_best;
                ram_d.ls  = r_acc;
                ram_d.cc  = alu_y;
                n_done    = 1'b1;
                n_status  = ST_SELECTED;
                n_tidx    = TIDX_W'(r_best_idx);
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_i     <= '0;
            r_have  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_i     <= n_i;
            r_have  <= n_have;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_tick     <= n_tick;
        r_dl       <= n_dl;
        r_wc       <= n_wc;
        r_per      <= n_per;
        r_acc      <= n_acc;
        r_missed   <= n_missed;
        r_status   <= n_status;
        r_tidx     <= n_tidx;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_task_index  = r_tidx;
    assign o_missed_mask = r_missed;

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while still busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_TASKS))
        else $error("task count beyond table depth");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_ADDED)) |-> (r_count == $past(r_count) + 1'b1))
        else $error("add result without table growth");

    a_add_no_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ((o_status == ST_ADDED) || (o_status == ST_FULL)))
            |-> (o_missed_mask == '0))
        else $error("missed mask set on add result");
`endif

endmodule

>>> bench/edf_checker.sv
`timescale 1ns / 1ps

module edf_checker #(
    parameter int MAX_TASKS = edf_pkg::MAX_TASKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic                          i_operation,
    input  logic [edf_pkg::TICK_W-1:0]    i_current_tick,
    input  logic [edf_pkg::TICK_W-1:0]    i_relative_deadline,
    input  logic [edf_pkg::TICK_W-1:0]    i_worst_case_time,
    input  logic [edf_pkg::TICK_W-1:0]    i_task_period,
    input  logic                          i_done,
    input  logic [edf_pkg::STATUS_W-1:0]  i_status,
    input  logic [edf_pkg::TIDX_W-1:0]    i_task_index,
    input  logic [edf_pkg::MASK_W-1:0]    i_missed_mask,
    output int                            o_mismatch_count,
    output int                            o_pending_count
);
    import edf_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TIDX_W-1:0]   task_index;
        logic [MASK_W-1:0]   missed_mask;
    } t_sched_result;

    t_task         task_table [MAX_TASKS];
    int unsigned   task_count;
    t_sched_result pending_results [$];
    t_sched_result oldest;
    int            mismatches;

    function automatic t_sched_result add_task(
        input logic [TICK_W-1:0] tick,
        input logic [TICK_W-1:0] deadline,
        input logic [TICK_W-1:0] wcet,
        input logic [TICK_W-1:0] period
    );
        t_sched_result res;
        res = '0;
        if (task_count >= MAX_TASKS) begin
            res.status = ST_FULL;
        end else begin
            task_table[task_count].dl  = deadline;
            task_table[task_count].wc  = wcet;
            task_table[task_count].per = period;
            task_table[task_count].ls  = tick + deadline - wcet;
            task_table[task_count].cc  = '0;
            res.status     = ST_ADDED;
            res.task_index = task_count[TIDX_W-1:0];
            task_count++;
        end
        return res;
    endfunction

    // scan in index order: restart missed tasks, keep earliest latest start,
    // ties to lower call count, then to lower index
    function automatic t_sched_result pick_task(input logic [TICK_W-1:0] tick);
        t_sched_result     res;
        logic [TICK_W-1:0] horizon;
        logic [TICK_W-1:0] lstart;
        bit                found;
        int                best;
        res   = '0;
        found = 1'b0;
        best  = 0;
        for (int i = 0; i < MAX_TASKS && i < task_count; i++) begin
            lstart  = task_table[i].ls;
            horizon = tick + task_table[i].dl;
            if (lstart <= horizon) begin
                if (lstart < tick) begin
                    task_table[i].ls = tick + task_table[i].dl - task_table[i].wc;
                    if (i < MASK_W)
                        res.missed_mask[i] = 1'b1;
                end else if (!found || lstart < task_table[best].ls ||
                             (lstart == task_table[best].ls &&
                              task_table[i].cc < task_table[best].cc)) begin
                    found = 1'b1;
                    best  = i;
                end
            end
        end
        if (found) begin
            task_table[best].cc = task_table[best].cc + 1'b1;
            task_table[best].ls = task_table[best].ls + task_table[best].per;
            res.status          = ST_SELECTED;
            res.task_index      = best[TIDX_W-1:0];
        end else begin
            res.status = ST_IDLE;
        end
        return res;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            task_count = 0;
            for (int i = 0; i < MAX_TASKS; i++)
                task_table[i] = '0;
            pending_results.delete();
        end else begin
            // a result beat is for an item taken at an earlier edge
            if (i_done === 1'b1) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, %s %0d index %0d mask %h",
                             $time, "got status", i_status, i_task_index, i_missed_mask);
                    mismatches++;
                end else begin
                    oldest = pending_results.pop_front();
                    check_field("status", 8'(oldest.status), 8'(i_status));
                    check_field("task_index", 8'(oldest.task_index), 8'(i_task_index));
                    check_field("missed_mask", 8'(oldest.missed_mask), 8'(i_missed_mask));
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                if (i_operation == OP_ADD)
                    pending_results.push_back(add_task(i_current_tick, i_relative_deadline,
                                                       i_worst_case_time, i_task_period));
                else
                    pending_results.push_back(pick_task(i_current_tick));
            end
        end
        o_mismatch_count <= mismatches;
        o_pending_count  <= pending_results.size();
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import edf_pkg::*;

    localparam int NUM_RANDOM  = 1625;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_WAIT  = 64;
    localparam logic [TICK_W-1:0] ALL_ONES = '1;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                start        = 1'b0;
    logic                operation    = OP_SCHEDULE;
    logic [TICK_W-1:0]   cur_tick     = '0;
    logic [TICK_W-1:0]   rel_deadline = '0;
    logic [TICK_W-1:0]   wc_time      = '0;
    logic [TICK_W-1:0]   task_period  = '0;
    logic                busy;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [TIDX_W-1:0]   task_index;
    logic [MASK_W-1:0]   missed_mask;

    int                  mismatch_count;
    int                  pending_count;
    int                  stall_cycles = 0;
    int                  gap;
    int                  roll;
    logic [TICK_W-1:0]   sched_tick;

    always #2 clk = ~clk;

    edf_latest_start_scheduler dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .start               (start),
        .busy                (busy),
        .i_operation         (operation),
        .i_current_tick      (cur_tick),
        .i_relative_deadline (rel_deadline),
        .i_worst_case_time   (wc_time),
        .i_task_period       (task_period),
        .o_done              (done),
        .o_status            (status),
        .o_task_index        (task_index),
        .o_missed_mask       (missed_mask)
    );

    edf_checker result_check (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_start             (start),
        .i_busy              (busy),
        .i_operation         (operation),
        .i_current_tick      (cur_tick),
        .i_relative_deadline (rel_deadline),
        .i_worst_case_time   (wc_time),
        .i_task_period       (task_period),
        .i_done              (done),
        .i_status            (status),
        .i_task_index        (task_index),
        .i_missed_mask       (missed_mask),
        .o_mismatch_count    (mismatch_count),
        .o_pending_count     (pending_count)
    );

    // start stays high from one accepted beat into the next unless a gap follows
    task automatic issue_item(input logic op, input logic [TICK_W-1:0] tick,
                              input logic [TICK_W-1:0] deadline,
                              input logic [TICK_W-1:0] wcet,
                              input logic [TICK_W-1:0] period, input int idle);
        for (int k = 0; k < idle; k++) begin
            start <= 1'b0;
            @(posedge clk);
        end
        operation    <= op;
        cur_tick     <= tick;
        rel_deadline <= deadline;
        wc_time      <= wcet;
        task_period  <= period;
        start        <= 1'b1;
        do @(posedge clk); while (busy !== 1'b0);
    endtask

    always @(posedge clk) begin
        if ((start && !busy) || done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, both tick extremes
        issue_item(OP_SCHEDULE, '0, ALL_ONES, ALL_ONES, ALL_ONES, 0);
        issue_item(OP_SCHEDULE, ALL_ONES, '0, '0, '0, 2);
        // latest start of zero with a window covering the whole tick range
        issue_item(OP_ADD, '0, ALL_ONES, ALL_ONES, ALL_ONES, 0);
        issue_item(OP_SCHEDULE, '0, '0, '0, '0, 0);
        issue_item(OP_SCHEDULE, ALL_ONES, '0, '0, '0, 1);
        // zero window, two identical zero-period tasks for call count ties,
        // wcet beyond deadline (always missed), ordinary periodic tasks
        issue_item(OP_ADD, 32'd1000, 32'd0, 32'd0, 32'd0, 0);
        issue_item(OP_ADD, 32'd1000, 32'd100, 32'd10, 32'd0, 0);
        issue_item(OP_ADD, 32'd1000, 32'd100, 32'd10, 32'd0, 3);
        issue_item(OP_ADD, 32'd1000, 32'd50, 32'd200, 32'd25, 0);
        issue_item(OP_ADD, 32'd1000, 32'd40, 32'd5, 32'd40, 0);
        issue_item(OP_ADD, 32'd1000, 32'd12, 32'd3, 32'd7, 0);
        issue_item(OP_ADD, 32'd1000, 32'd0, 32'd1, 32'd1, 0);
        // table full
        issue_item(OP_ADD, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 0);
        issue_item(OP_ADD, '0, '0, '0, '0, 1);
        issue_item(OP_SCHEDULE, 32'd1000, '0, '0, '0, 0);
        issue_item(OP_SCHEDULE, 32'd1000, '0, '0, '0, 0);
        issue_item(OP_SCHEDULE, 32'd1003, '0, '0, '0, 0);
        issue_item(OP_SCHEDULE, 32'd1009, '0, '0, '0, 2);
        issue_item(OP_SCHEDULE, 32'd1090, '0, '0, '0, 0);
        issue_item(OP_SCHEDULE, 32'd1090, '0, '0, '0, 0);
        issue_item(OP_SCHEDULE, 32'd1091, '0, '0, '0, 0);
        issue_item(OP_SCHEDULE, ALL_ONES, '0, '0, '0, 0);

        // tick mostly creeps forward from the top so it wraps through zero
        sched_tick = ALL_ONES;
        for (int k = 0; k < NUM_RANDOM; k++) begin
            gap = 0;
            if (k < NUM_RANDOM - 250 && (k / 150) % 4 != 3 && $urandom_range(0, 2) == 0)
                gap = $urandom_range(1, 8);
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                issue_item(OP_ADD, $urandom(), $urandom(), $urandom(), $urandom(), gap);
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 80)
                    sched_tick = sched_tick + $urandom_range(0, 4);
                else if (roll < 92)
                    sched_tick = sched_tick + $urandom_range(5, 2000);
                else if (roll < 97)
                    sched_tick = $urandom();
                else
                    sched_tick = 32'hFFFF_FFF0 + $urandom_range(0, 15);
                issue_item(OP_SCHEDULE, sched_tick, $urandom(), $urandom(), $urandom(), gap);
            end
        end
        start <= 1'b0;

        do @(posedge clk); while (pending_count != 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
